// ----- src/wcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Write-back LRU block cache package
// Shared codes, control command and status types for the cache modules.
// ----------------------------------------------------------------------------
package wcc_pkg;

   localparam int OP_BITS   = 3;
   localparam int KIND_BITS = 3;
   localparam int CAP_BITS  = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic [OP_BITS-1:0] OP_READ   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_FILL   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_COMMIT = 3'd3;
   localparam logic [OP_BITS-1:0] OP_INVAL  = 3'd4;

   localparam logic [KIND_BITS-1:0] KIND_DATA  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_FETCH = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_WB    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_DONE  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_FAIL  = 3'd4;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOOKUP,
      ACT_READ_HIT,
      ACT_READ_MISS,
      ACT_WRITE_HIT,
      ACT_FILL_FAIL,
      ACT_INVALIDATE,
      ACT_EVICT_READ,
      ACT_EVICT,
      ACT_INSERT,
      ACT_COMMIT_START,
      ACT_COMMIT_SCAN,
      ACT_COMMIT_WB,
      ACT_COMMIT_SKIP,
      ACT_COMMIT_DONE
   } action_type;

   typedef struct packed {
      logic       latch_req;
      action_type act;
   } cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               hit;
      logic               pending;
      logic               fill_ok;
      logic               must_evict;
      logic               victim_dirty;
      logic               commit_found;
      logic               commit_end;
      logic               out_free;
   } status_type;

endpackage

// ----- src/wcc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wcc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wcc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache controller
// Sequences lookup, eviction, insertion and commit steps for one request.
// ----------------------------------------------------------------------------
module wcc_ctrl
   import wcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_EVICT_RD,
      ST_EVICT,
      ST_INSERT,
      ST_SCAN,
      ST_WB
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.latch_req = 1'b0;
      cmd.act       = ACT_NONE;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.act  = ACT_LOOKUP;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            unique case (status.op)
               OP_READ: begin
                  if (status.out_free) begin
                     cmd.act  = status.hit ? ACT_READ_HIT : ACT_READ_MISS;
                     state_in = ST_IDLE;
                  end
               end
               OP_WRITE: begin
                  if (status.hit) begin
                     if (status.out_free) begin
                        cmd.act  = ACT_WRITE_HIT;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     state_in = status.must_evict ? ST_EVICT_RD : ST_INSERT;
                  end
               end
               OP_FILL: begin
                  if (!status.pending) begin
                     state_in = ST_IDLE;
                  end else if (status.fill_ok) begin
                     state_in = status.must_evict ? ST_EVICT_RD : ST_INSERT;
                  end else if (status.out_free) begin
                     cmd.act  = ACT_FILL_FAIL;
                     state_in = ST_IDLE;
                  end
               end
               OP_COMMIT: begin
                  cmd.act  = ACT_COMMIT_START;
                  state_in = ST_SCAN;
               end
               OP_INVAL: begin
                  if (status.out_free) begin
                     cmd.act  = ACT_INVALIDATE;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EVICT_RD: begin
            cmd.act  = ACT_EVICT_READ;
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (!status.victim_dirty || status.out_free) begin
               cmd.act  = ACT_EVICT;
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (status.out_free) begin
               cmd.act  = ACT_INSERT;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.commit_end) begin
               if (status.out_free) begin
                  cmd.act  = ACT_COMMIT_DONE;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.act  = ACT_COMMIT_SCAN;
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (!status.commit_found) begin
               cmd.act  = ACT_COMMIT_SKIP;
               state_in = ST_SCAN;
            end else if (status.out_free) begin
               cmd.act  = ACT_COMMIT_WB;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/wcc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache datapath
// Tag match, recency ranks, line RAM, miss tracking and the result register.
// ----------------------------------------------------------------------------
module wcc_datapath
   import wcc_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int LINE_BITS  = 64,
   parameter int INDEX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [OP_BITS-1:0]    req_operation,
   input  logic [INDEX_BITS-1:0] req_block_index,
   input  logic [LINE_BITS-1:0]  req_line_data,
   input  logic                  req_fill_ok,
   input  logic                  csr_valid,
   input  logic [CAP_BITS-1:0]   csr_capacity,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_BITS-1:0]  rsp_kind,
   output logic [INDEX_BITS-1:0] rsp_out_index,
   output logic [LINE_BITS-1:0]  rsp_out_data,
   output logic                  rsp_last
);

   localparam int SB = $clog2(ENTRIES);
   localparam int CB = $clog2(ENTRIES + 1);
   localparam int WW = (CB > CAP_BITS) ? CB : CAP_BITS;

   logic [OP_BITS-1:0]    req_op_ff;
   logic [INDEX_BITS-1:0] req_idx_ff;
   logic [LINE_BITS-1:0]  req_data_ff;
   logic                  req_ok_ff;

   logic [INDEX_BITS-1:0] tag_ff [ENTRIES];
   logic [SB-1:0]         rank_ff [ENTRIES];
   logic [SB-1:0]         rank_in [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in, dirty_ff, dirty_in;
   logic [CB-1:0]         count_ff, count_in, scan_ff, scan_in;
   logic                  pending_ff, pending_in;
   logic [INDEX_BITS-1:0] pidx_ff, pidx_in;
   logic [CAP_BITS-1:0]   cap_ff;
   logic                  hit_ff, hit_in, found_ff, found_in;
   logic [SB-1:0]         slot_ff, slot_in, victim_ff, victim_in, cslot_ff, cslot_in;

   logic                  hit_c, found_c;
   logic [SB-1:0]         hit_slot_c, victim_c, cslot_c, free_c;
   logic                  free_seen;
   logic [SB-1:0]         lru_rank;
   logic [WW-1:0]         cap_w, eff_cap;

   logic                  tag_we;
   logic [INDEX_BITS-1:0] tag_wdata;

   logic                  ram_we, ram_re;
   logic [SB-1:0]         ram_waddr, ram_raddr;
   logic [LINE_BITS-1:0]  ram_rdata;

   logic                  emit, emit_last;
   logic [KIND_BITS-1:0]  emit_kind;
   logic [INDEX_BITS-1:0] emit_idx;
   logic [LINE_BITS-1:0]  emit_data;

   logic                  rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   logic [KIND_BITS-1:0]  rsp_kind_ff;
   logic [INDEX_BITS-1:0] rsp_idx_ff;
   logic [LINE_BITS-1:0]  rsp_data_ff;

   assign lru_rank = SB'(count_ff - CB'(1));

   always_comb begin
      hit_c      = 1'b0;
      hit_slot_c = '0;
      victim_c   = '0;
      found_c    = 1'b0;
      cslot_c    = '0;
      free_c     = '0;
      free_seen  = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && tag_ff[i] == req_idx_ff && !hit_c) begin
            hit_c      = 1'b1;
            hit_slot_c = SB'(i);
         end
         if (valid_ff[i] && rank_ff[i] == lru_rank) begin
            victim_c = SB'(i);
         end
         if (valid_ff[i] && dirty_ff[i] && rank_ff[i] == scan_ff[SB-1:0] && !found_c) begin
            found_c = 1'b1;
            cslot_c = SB'(i);
         end
         if (!valid_ff[i] && !free_seen) begin
            free_seen = 1'b1;
            free_c    = SB'(i);
         end
      end
   end

   always_comb begin
      cap_w = WW'(cap_ff);
      if (cap_w == '0) begin
         eff_cap = WW'(1);
      end else if (cap_w > WW'(ENTRIES)) begin
         eff_cap = WW'(ENTRIES);
      end else begin
         eff_cap = cap_w;
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      dirty_in   = dirty_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      pending_in = pending_ff;
      pidx_in    = pidx_ff;
      hit_in     = hit_ff;
      slot_in    = slot_ff;
      victim_in  = victim_ff;
      found_in   = found_ff;
      cslot_in   = cslot_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      tag_we    = 1'b0;
      tag_wdata = req_idx_ff;
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_re    = 1'b0;
      ram_raddr = hit_slot_c;
      emit      = 1'b0;
      emit_last = 1'b1;
      emit_kind = KIND_DONE;
      emit_idx  = '0;
      emit_data = '0;
      unique case (cmd.act)
         ACT_NONE: begin
         end
         ACT_LOOKUP: begin
            hit_in    = hit_c;
            slot_in   = hit_slot_c;
            ram_re    = 1'b1;
            ram_raddr = hit_slot_c;
         end
         ACT_READ_HIT: begin
            pending_in = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && rank_ff[i] < rank_ff[slot_ff]) begin
                  rank_in[i] = rank_ff[i] + SB'(1);
               end
            end
            rank_in[slot_ff] = '0;
            emit      = 1'b1;
            emit_kind = KIND_DATA;
            emit_idx  = req_idx_ff;
            emit_data = ram_rdata;
         end
         ACT_READ_MISS: begin
            pending_in = 1'b1;
            pidx_in    = req_idx_ff;
            emit       = 1'b1;
            emit_kind  = KIND_FETCH;
            emit_idx   = req_idx_ff;
         end
         ACT_WRITE_HIT: begin
            pending_in = 1'b0;
            if (ram_rdata != req_data_ff) begin
               ram_we            = 1'b1;
               ram_waddr         = slot_ff;
               dirty_in[slot_ff] = 1'b1;
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && rank_ff[i] < rank_ff[slot_ff]) begin
                  rank_in[i] = rank_ff[i] + SB'(1);
               end
            end
            rank_in[slot_ff] = '0;
            emit             = 1'b1;
         end
         ACT_FILL_FAIL: begin
            pending_in = 1'b0;
            emit       = 1'b1;
            emit_kind  = KIND_FAIL;
            emit_idx   = pidx_ff;
         end
         ACT_INVALIDATE: begin
            valid_in   = '0;
            dirty_in   = '0;
            count_in   = '0;
            pending_in = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
               rank_in[i] = '0;
            end
            emit = 1'b1;
         end
         ACT_EVICT_READ: begin
            victim_in = victim_c;
            ram_re    = 1'b1;
            ram_raddr = victim_c;
         end
         ACT_EVICT: begin
            if (dirty_ff[victim_ff]) begin
               emit      = 1'b1;
               emit_last = 1'b0;
               emit_kind = KIND_WB;
               emit_idx  = tag_ff[victim_ff];
               emit_data = ram_rdata;
            end
            valid_in[victim_ff] = 1'b0;
            dirty_in[victim_ff] = 1'b0;
            rank_in[victim_ff]  = '0;
            count_in            = count_ff - CB'(1);
         end
         ACT_INSERT: begin
            pending_in = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + SB'(1);
               end
            end
            rank_in[free_c]  = '0;
            valid_in[free_c] = 1'b1;
            dirty_in[free_c] = (req_op_ff == OP_WRITE);
            count_in         = count_ff + CB'(1);
            tag_we           = 1'b1;
            tag_wdata        = (req_op_ff == OP_WRITE) ? req_idx_ff : pidx_ff;
            ram_we           = 1'b1;
            ram_waddr        = free_c;
            emit             = 1'b1;
            if (req_op_ff != OP_WRITE) begin
               emit_kind = KIND_DATA;
               emit_idx  = pidx_ff;
               emit_data = req_data_ff;
            end
         end
         ACT_COMMIT_START: begin
            scan_in = '0;
         end
         ACT_COMMIT_SCAN: begin
            found_in  = found_c;
            cslot_in  = cslot_c;
            ram_re    = 1'b1;
            ram_raddr = cslot_c;
         end
         ACT_COMMIT_WB: begin
            dirty_in[cslot_ff] = 1'b0;
            scan_in            = scan_ff + CB'(1);
            emit               = 1'b1;
            emit_last          = 1'b0;
            emit_kind          = KIND_WB;
            emit_idx           = tag_ff[cslot_ff];
            emit_data          = ram_rdata;
         end
         ACT_COMMIT_SKIP: begin
            scan_in = scan_ff + CB'(1);
         end
         ACT_COMMIT_DONE: begin
            emit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         pending_ff   <= 1'b0;
         pidx_ff      <= '0;
         cap_ff       <= CAP_RESET;
         hit_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         pending_ff   <= pending_in;
         pidx_ff      <= pidx_in;
         hit_ff       <= hit_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      victim_ff <= victim_in;
      cslot_ff  <= cslot_in;
      if (cmd.latch_req) begin
         req_op_ff   <= req_operation;
         req_idx_ff  <= req_block_index;
         req_data_ff <= req_line_data;
         req_ok_ff   <= req_fill_ok;
      end
      if (tag_we) begin
         tag_ff[free_c] <= tag_wdata;
      end
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_idx_ff  <= emit_idx;
         rsp_data_ff <= emit_data;
         rsp_last_ff <= emit_last;
      end
   end

   wcc_ram #(
      .WIDTH(LINE_BITS),
      .DEPTH(ENTRIES)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(req_data_ff),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign status.op           = req_op_ff;
   assign status.hit          = hit_ff;
   assign status.pending      = pending_ff;
   assign status.fill_ok      = req_ok_ff;
   assign status.must_evict   = (WW'(count_ff) >= eff_cap);
   assign status.victim_dirty = dirty_ff[victim_ff];
   assign status.commit_found = found_ff;
   assign status.commit_end   = (scan_ff >= count_ff);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_out_data  = rsp_data_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- src/write_back_lru_block_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Write-back LRU block cache
// Fully associative cache of block lines with a runtime capacity limit.
//
// Requests arrive on the req_ channel (read, write, fill, commit, invalidate)
// and are taken one at a time; req_ready is high only while no request is in
// progress. Each request gives zero or more beats on the rsp_ channel, the
// final one flagged by rsp_last. The csr_ channel writes the capacity and is
// always ready. A read hit or miss, write hit, failed fill or invalidate
// passes through the lookup and decide states; its result beat loads at
// the same edge at which req_ready comes back. An insert adds the insert
// state, and the evict-read and evict states before it when it evicts the
// LRU entry. Commit walks the recency ranks with a scan and a write-back
// step per held entry and a done step, set by the registered line RAM read.
// A single output register holds each beat; while the receiver stalls, the
// controller waits before producing the next beat. Reset empties the cache,
// clears any pending miss and sets the capacity to 16; no clearing pass.
// ----------------------------------------------------------------------------
module write_back_lru_block_cache
   import wcc_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int LINE_BITS  = 64,
   parameter int INDEX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_BITS-1:0]    req_operation,
   input  logic [INDEX_BITS-1:0] req_block_index,
   input  logic [LINE_BITS-1:0]  req_line_data,
   input  logic                  req_fill_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_BITS-1:0]  rsp_kind,
   output logic [INDEX_BITS-1:0] rsp_out_index,
   output logic [LINE_BITS-1:0]  rsp_out_data,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_BITS-1:0]   csr_capacity
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   wcc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   wcc_datapath #(
      .ENTRIES   (ENTRIES),
      .LINE_BITS (LINE_BITS),
      .INDEX_BITS(INDEX_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_block_index(req_block_index),
      .req_line_data  (req_line_data),
      .req_fill_ok    (req_fill_ok),
      .csr_valid      (csr_valid),
      .csr_capacity   (csr_capacity),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_data   (rsp_out_data),
      .rsp_last       (rsp_last)
   );

endmodule
